// ===== rtl/rilp_pkg.sv =====
// Shared types and constants for the radix integer literal parser.
// It has no dependencies. The step logic and the top level use it.
package rilp_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Radix codes carried with each character.
  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  // Character bounds for hex digit decoding.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;

  // Digit code for a character that is not a hex digit.
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  // Number of prefix characters skipped for a non-decimal radix.
  localparam logic [1:0] PREFIX_LEN = 2'd2;

  // Width of the result value field.
  localparam int unsigned OUT_VALUE_W = 64;

  // Per-literal control state.
  typedef struct packed {
    logic [1:0] prefix_seen;
    status_t    err;
  } ctl_t;

endpackage

// ===== rtl/rilp_step.sv =====
// Combinational step logic: digit decode, multiply-accumulate by the radix,
// limit check and result status. Depends on rilp_pkg.
module rilp_step #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [7:0]              ch,
  input  logic [1:0]              base_code,
  input  logic                    unsigned_limit,
  input  logic                    last,
  input  logic [VALUE_WIDTH-1:0]  acc,
  input  rilp_pkg::ctl_t          ctl,
  output logic [VALUE_WIDTH-1:0]  acc_nxt,
  output rilp_pkg::ctl_t          ctl_nxt,
  output logic [VALUE_WIDTH-1:0]  res_value,
  output rilp_pkg::status_t       res_status
);

  localparam int unsigned PW = VALUE_WIDTH + 4;
  localparam int unsigned SW = VALUE_WIDTH + 5;

  logic [4:0]             digit;
  logic                   digit_ok;
  logic                   is_prefix;
  logic [PW-1:0]          prod;
  logic [SW-1:0]          sum;
  logic [VALUE_WIDTH-1:0] limit;
  logic                   ovf;
  logic [VALUE_WIDTH-1:0] acc_upd;
  rilp_pkg::ctl_t         ctl_upd;
  rilp_pkg::status_t      status;

  // Hex digit decode; anything else maps to the no-digit code.
  always_comb begin
    if (ch >= rilp_pkg::CH_0 && ch <= rilp_pkg::CH_9) begin
      digit = 5'(ch - rilp_pkg::CH_0);
    end else if (ch >= rilp_pkg::CH_UP_A && ch <= rilp_pkg::CH_UP_F) begin
      digit = 5'(ch - rilp_pkg::CH_UP_A) + 5'd10;
    end else if (ch >= rilp_pkg::CH_LOW_A && ch <= rilp_pkg::CH_LOW_F) begin
      digit = 5'(ch - rilp_pkg::CH_LOW_A) + 5'd10;
    end else begin
      digit = rilp_pkg::DIGIT_NONE;
    end
  end

  // Digit must be below the radix.
  always_comb begin
    case (base_code)
      rilp_pkg::BASE_BIN: digit_ok = (digit < 5'd2);
      rilp_pkg::BASE_OCT: digit_ok = (digit < 5'd8);
      rilp_pkg::BASE_DEC: digit_ok = (digit < 5'd10);
      default:            digit_ok = (digit < 5'd16);
    endcase
  end

  // Accumulator times radix as shifts and adds.
  always_comb begin
    case (base_code)
      rilp_pkg::BASE_BIN: prod = {3'b000, acc, 1'b0};
      rilp_pkg::BASE_OCT: prod = {1'b0, acc, 3'b000};
      rilp_pkg::BASE_DEC: prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
      default:            prod = {acc, 4'b0000};
    endcase
  end

  // The new value passes the limit exactly when acc * base + digit > limit.
  assign sum   = {1'b0, prod} + SW'(digit);
  assign limit = unsigned_limit ? {VALUE_WIDTH{1'b1}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  assign ovf   = (sum > SW'(limit));

  assign is_prefix = (base_code != rilp_pkg::BASE_DEC) && (ctl.prefix_seen < rilp_pkg::PREFIX_LEN);

  // State update for this character; a latched error freezes the value.
  always_comb begin
    acc_upd = acc;
    ctl_upd = ctl;
    if (is_prefix) begin
      ctl_upd.prefix_seen = 2'(ctl.prefix_seen + 2'd1);
    end else if (ctl.err == rilp_pkg::ST_OK) begin
      if (!digit_ok) begin
        ctl_upd.err = rilp_pkg::ST_MALFORMED;
      end else if (ovf) begin
        ctl_upd.err = rilp_pkg::ST_OVERFLOW;
      end else begin
        acc_upd = sum[VALUE_WIDTH-1:0];
      end
    end
  end

  // Result status; a literal ending inside its prefix has no digits.
  always_comb begin
    status = ctl_upd.err;
    if (is_prefix && status == rilp_pkg::ST_OK) begin
      status = rilp_pkg::ST_MALFORMED;
    end
  end

  assign res_status = status;
  assign res_value  = (status == rilp_pkg::ST_OK) ? acc_upd : '0;

  // The last character returns the state to its cleared form.
  always_comb begin
    if (last) begin
      acc_nxt = '0;
      ctl_nxt = '{prefix_seen: 2'd0, err: rilp_pkg::ST_OK};
    end else begin
      acc_nxt = acc_upd;
      ctl_nxt = ctl_upd;
    end
  end

endmodule

// ===== rtl/radix_integer_literal_parser_unit.sv =====
// Flow: an accepted character is held in the input register, then parsed into the
// literal state when it advances; a last character also loads the result register,
// which raises out_tvalid.
// Throughput: one character per cycle, set by the combinational shift-add and
// limit compare in the step logic; a held result stalls only a last character.
// Reset (rst_n low, synchronous) clears the input stage, the output stage and
// the accumulator and prefix/error state. Depends on rilp_pkg and rilp_step.
module radix_integer_literal_parser_unit #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input characters.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic [2:0]  in_tuser,   // [1:0] base_code, [2] unsigned_limit
  input  logic        in_tlast,   // last
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic                   in_valid_r;
  logic [7:0]             in_ch_r;
  logic [1:0]             in_code_r;
  logic                   in_uns_r;
  logic                   in_last_r;
  logic                   advance;

  logic [VALUE_WIDTH-1:0] acc_r;
  logic [VALUE_WIDTH-1:0] acc_nxt;
  rilp_pkg::ctl_t         ctl_r;
  rilp_pkg::ctl_t         ctl_nxt;
  logic [VALUE_WIDTH-1:0] res_value;
  rilp_pkg::status_t      res_status;

  logic                   out_valid_r;
  logic [63:0]            out_value_r;
  logic [1:0]             out_status_r;

  // A registered character moves on unless it is last and the result slot is busy.
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_ch_r   <= in_tdata;
      in_code_r <= in_tuser[1:0];
      in_uns_r  <= in_tuser[2];
      in_last_r <= in_tlast;
    end
  end

  rilp_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .ch             (in_ch_r),
    .base_code      (in_code_r),
    .unsigned_limit (in_uns_r),
    .last           (in_last_r),
    .acc            (acc_r),
    .ctl            (ctl_r),
    .acc_nxt        (acc_nxt),
    .ctl_nxt        (ctl_nxt),
    .res_value      (res_value),
    .res_status     (res_status)
  );

  // Literal state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ctl_r <= '{prefix_seen: 2'd0, err: rilp_pkg::ST_OK};
    end else if (advance) begin
      acc_r <= acc_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  // Result register; loaded when a last character completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && in_last_r) begin
      out_value_r  <= rilp_pkg::OUT_VALUE_W'(res_value);
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

// ===== tb/tb_radix_integer_literal_parser_unit.sv =====
// Self-checking testbench for radix_integer_literal_parser_unit: it streams literals of every
// radix, checks each parsed value and status against a built-in predictor, and stalls both sides.
// Depends on rilp_pkg and the RTL of the parser unit.
`timescale 1ns / 1ps

module tb_radix_integer_literal_parser_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 210;
  localparam int DRAIN_CYCLES = 20;

  // One character transaction on the input stream.
  typedef struct {
    logic [7:0] ch;
    logic [1:0] code;
    logic       uns;
    logic       last;
  } char_item_t;

  // One expected parse result.
  typedef struct {
    logic [63:0]       value;
    rilp_pkg::status_t status;
  } literal_result_t;

  // Predicts the parser and compares its results in order.
  class literal_checker;
    logic [63:0]       acc;
    logic [1:0]        prefix_cnt;
    rilp_pkg::status_t err;
    literal_result_t   pending_literals[$];
    int                errors;

    function new();
      acc = '0;
      prefix_cnt = '0;
      err = rilp_pkg::ST_OK;
      errors = 0;
    endfunction

    function int pending();
      return pending_literals.size();
    endfunction

    // Digit value of a character, 16 when it is no hex digit.
    function logic [63:0] hex_value(logic [7:0] ch);
      if (ch >= rilp_pkg::CH_0 && ch <= rilp_pkg::CH_9) return 64'(ch - rilp_pkg::CH_0);
      if (ch >= rilp_pkg::CH_UP_A && ch <= rilp_pkg::CH_UP_F)
        return 64'(ch - rilp_pkg::CH_UP_A) + 64'd10;
      if (ch >= rilp_pkg::CH_LOW_A && ch <= rilp_pkg::CH_LOW_F)
        return 64'(ch - rilp_pkg::CH_LOW_A) + 64'd10;
      return 64'd16;
    endfunction

    // Advances the predicted state by one accepted character.
    function void note_char(char_item_t it);
      logic [63:0]     base;
      logic [63:0]     d;
      logic [63:0]     limit;
      bit              digit_pos;
      literal_result_t res;
      case (it.code)
        rilp_pkg::BASE_BIN: base = 64'd2;
        rilp_pkg::BASE_OCT: base = 64'd8;
        rilp_pkg::BASE_DEC: base = 64'd10;
        default:            base = 64'd16;
      endcase
      digit_pos = 1'b1;
      if (it.code != rilp_pkg::BASE_DEC && prefix_cnt < rilp_pkg::PREFIX_LEN) begin
        prefix_cnt = prefix_cnt + 2'd1;
        digit_pos = 1'b0;
      end else if (err == rilp_pkg::ST_OK) begin
        d = hex_value(it.ch);
        if (d >= base) begin
          err = rilp_pkg::ST_MALFORMED;
        end else begin
          limit = it.uns ? {64{1'b1}} : {1'b0, {63{1'b1}}};
          if (acc > (limit - d) / base) err = rilp_pkg::ST_OVERFLOW;
          else acc = acc * base + d;
        end
      end
      if (it.last) begin
        res.status = err;
        // A literal that ends inside its prefix has no digits.
        if (!digit_pos && res.status == rilp_pkg::ST_OK) res.status = rilp_pkg::ST_MALFORMED;
        res.value = (res.status == rilp_pkg::ST_OK) ? acc : 64'd0;
        pending_literals.push_back(res);
        acc = '0;
        prefix_cnt = '0;
        err = rilp_pkg::ST_OK;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one result transaction with the oldest prediction.
    task check_literal(logic [63:0] value, logic [1:0] status);
      literal_result_t exp_res;
      if (pending_literals.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h status %0d", value, status));
      end else begin
        exp_res = pending_literals.pop_front();
        if (status !== exp_res.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status, exp_res.status));
        if (value !== exp_res.value)
          report_mismatch($sformatf("value %h, predicted %h", value, exp_res.value));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [2:0]  in_tuser = '0;   // [1:0] base_code, [2] unsigned_limit
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] value
  logic [1:0]  out_tuser;       // [1:0] status

  literal_checker sb;
  char_item_t     lit_q[$];
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  int             sent_cnt = 0;
  int             cycle_cnt = 0;

  radix_integer_literal_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_literal(out_tdata, out_tuser);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_char(logic [7:0] ch, logic [1:0] code, logic uns, logic last);
    char_item_t it;
    it.ch = ch;
    it.code = code;
    it.uns = uns;
    it.last = last;
    lit_q.push_back(it);
  endtask

  // Queues a whole literal from text, marking its final character.
  task automatic push_text(string s, logic [1:0] code, logic uns);
    for (int k = 0; k < s.len(); k++) push_char(s[k], code, uns, k == s.len() - 1);
  endtask

  function automatic logic [7:0] digit_char(int d, bit upper);
    if (d < 10) return rilp_pkg::CH_0 + 8'(d);
    return (upper ? rilp_pkg::CH_UP_A : rilp_pkg::CH_LOW_A) + 8'(d - 10);
  endfunction

  // Queues one random literal: mostly well-formed, with near-limit values, some noise.
  task automatic gen_literal();
    logic [1:0]  code;
    logic        uns;
    int          base;
    int          n;
    logic [63:0] lim;
    logic [63:0] target;
    logic [7:0]  ch;
    int          digits[$];
    bit          upper;
    code = 2'($urandom_range(0, 3));
    uns = 1'($urandom_range(0, 1));
    // Noise: random bytes with the radix and limit changing per character.
    if ($urandom_range(0, 99) < 25) begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++)
        push_char(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), k == n - 1);
      return;
    end
    case (code)
      rilp_pkg::BASE_BIN: base = 2;
      rilp_pkg::BASE_OCT: base = 8;
      rilp_pkg::BASE_DEC: base = 10;
      default:            base = 16;
    endcase
    lim = uns ? {64{1'b1}} : {1'b0, {63{1'b1}}};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: target = 64'($urandom_range(0, 999));
      4, 5:       target = {$urandom, $urandom} >> $urandom_range(0, 63);
      6:          target = lim - 64'($urandom_range(0, 3));
      7:          target = lim;
      8:          target = lim + 64'd1;
      default:    target = {$urandom, $urandom};
    endcase
    do begin
      digits.push_front(int'(target % base));
      target = target / base;
    end while (target != 0);
    if ($urandom_range(0, 99) < 20) repeat ($urandom_range(1, 3)) digits.push_front(0);
    // An extra trailing digit pushes large values past the limit.
    if ($urandom_range(0, 99) < 15) digits.push_back(int'($urandom_range(0, base - 1)));
    if (code != rilp_pkg::BASE_DEC) begin
      push_char(($urandom_range(0, 1) != 0) ? rilp_pkg::CH_0 : 8'($urandom_range(0, 255)),
                code, uns, 1'b0);
      case (code)
        rilp_pkg::BASE_BIN: ch = "b";
        rilp_pkg::BASE_OCT: ch = "o";
        default:            ch = "x";
      endcase
      if ($urandom_range(0, 1) == 0) ch = 8'($urandom_range(0, 255));
      // Occasionally the literal stops right after its prefix.
      if ($urandom_range(0, 99) < 5) begin
        push_char(ch, code, uns, 1'b1);
        return;
      end
      push_char(ch, code, uns, 1'b0);
    end
    upper = 1'($urandom_range(0, 1));
    for (int k = 0; k < digits.size(); k++) begin
      ch = digit_char(digits[k], upper);
      if ($urandom_range(0, 99) < 3) ch = 8'($urandom_range(0, 255));
      push_char(ch, code, uns, k == digits.size() - 1);
    end
  endtask

  // Drives one character transaction; starts and ends at a falling edge.
  task automatic send_char(char_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.ch;
    in_tuser  <= {it.uns, it.code};
    in_tlast  <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(it);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (lit_q.size() != 0) send_char(lit_q.pop_front());
  endtask

  // Holds the input idle until every predicted result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 80;
        end
        1: begin
          tx_idle_pct = 80;
          rx_idle_pct = 8;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent_cnt = 0;
      if (phase == 0) begin
        // Directed literals: simple digits, prefix-only, bad digits, latched errors.
        push_text("7", rilp_pkg::BASE_DEC, 1'b0);
        push_text("0x", rilp_pkg::BASE_HEX, 1'b0);
        push_text("0b1", rilp_pkg::BASE_BIN, 1'b1);
        push_text("0o8", rilp_pkg::BASE_OCT, 1'b0);
        push_text("0xfF", rilp_pkg::BASE_HEX, 1'b1);
        push_text("z12", rilp_pkg::BASE_DEC, 1'b0);
        push_text("0xG", rilp_pkg::BASE_HEX, 1'b1);
        push_char(8'hFF, rilp_pkg::BASE_DEC, 1'b1, 1'b1);
        push_char(8'h00, rilp_pkg::BASE_DEC, 1'b0, 1'b1);
        // Radix changes in the middle of a literal.
        push_char("0", rilp_pkg::BASE_HEX, 1'b0, 1'b0);
        push_char("x", rilp_pkg::BASE_HEX, 1'b0, 1'b0);
        push_char("9", rilp_pkg::BASE_DEC, 1'b1, 1'b1);
        push_char("5", rilp_pkg::BASE_DEC, 1'b0, 1'b0);
        push_char("A", rilp_pkg::BASE_HEX, 1'b0, 1'b1);
        send_queued();
      end
      while (sent_cnt < PHASE_ITEMS) begin
        gen_literal();
        send_queued();
      end
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rilp_pkg.sv
rtl/rilp_step.sv
rtl/radix_integer_literal_parser_unit.sv
tb/tb_radix_integer_literal_parser_unit.sv
